@@ src/skvl_pkg.sv @@
// shared types, constants and helpers of the sorted key/value list
`default_nettype none
package skvl_pkg;

	// list geometry
	localparam int CAPACITY = 32;
	localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// beat field widths
	localparam int OP_W   = 3;
	localparam int KEY_W  = 16;
	localparam int VAL_W  = 32;
	localparam int IPOS_W = 5;
	localparam int OPOS_W = 5;
	localparam int OCNT_W = 6;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE_KEY   = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_INDEX = 3'd2;
	localparam logic [OP_W-1:0] OP_LOOKUP_KEY   = 3'd3;
	localparam logic [OP_W-1:0] OP_LOOKUP_INDEX = 3'd4;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NOT_FOUND,
		STAT_FULL,
		STAT_RANGE
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	// one captured input beat
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [KEY_W-1:0]         key;
		logic signed [VAL_W-1:0]  value;
		logic [IPOS_W-1:0]        pos;
	} item_t;

	// one result beat
	typedef struct packed {
		status_t                  status;
		logic [KEY_W-1:0]         key;
		logic signed [VAL_W-1:0]  value;
		logic [OPOS_W-1:0]        pos;
		logic [CNT_W-1:0]         count;
	} res_t;

	// shift command broadcast to the cell row
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [POS_W-1:0] at;
	} cmd_t;

	// priority encoder: hit flag and index of the lowest set bit
	function automatic logic [POS_W:0] first_set(input logic [CAPACITY-1:0] v);
		logic [POS_W:0] r;
		r = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, POS_W'(i)};
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ src/sorted_key_value_list.sv @@
// Sorted key/value list: a row of 32 slot cells kept in ascending signed value order,
// serving insert, remove by key or index and lookup by key or index. Each beat runs
// in steps: the accept edge captures it, the compare state registers every cell's
// compare flags, and the apply state picks the target slot, shifts the cell row and writes
// the result register; only then does the sequencer return to idle and accept the next
// beat, so one beat at a time passes the compare-then-shift sequence over the cell row. A result
// waiting on out_stall does not block acceptance, but the shift of the following beat
// waits until the output register is free. No clearing pass after reset: the entry
// count alone marks which cells hold entries.
`default_nettype none
module sorted_key_value_list (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [skvl_pkg::OP_W-1:0]         operation,
	input  wire logic [skvl_pkg::KEY_W-1:0]        item_key,
	input  wire logic signed [skvl_pkg::VAL_W-1:0] item_value,
	input  wire logic [skvl_pkg::IPOS_W-1:0]       position,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [1:0]                             status,
	output logic [skvl_pkg::KEY_W-1:0]             found_key,
	output logic signed [skvl_pkg::VAL_W-1:0]      found_value,
	output logic [skvl_pkg::OPOS_W-1:0]            found_position,
	output logic [skvl_pkg::OCNT_W-1:0]            entry_count
);

	skvl_pkg::state_t              state_q, state_nxt;
	skvl_pkg::item_t               item_q;
	skvl_pkg::res_t                res, out_res_q;
	skvl_pkg::cmd_t                cmd, cell_cmd;
	logic [skvl_pkg::CNT_W-1:0]    count_q;
	logic                          out_valid_q;
	logic                          accept;
	logic                          cmp_en;
	logic                          go;
	logic [skvl_pkg::CAPACITY-1:0] gt_vec;
	logic [skvl_pkg::CAPACITY-1:0] match_vec;
	logic [skvl_pkg::KEY_W-1:0]        key_a [skvl_pkg::CAPACITY];
	logic signed [skvl_pkg::VAL_W-1:0] val_a [skvl_pkg::CAPACITY];

	assign accept = in_valid && !in_stall;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skvl_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and strobes
	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		cmp_en    = 1'b0;
		go        = 1'b0;
		case (state_q)
			skvl_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = skvl_pkg::S_CMP;
				end
			end
			skvl_pkg::S_CMP: begin
				cmp_en    = 1'b1;
				state_nxt = skvl_pkg::S_APPLY;
			end
			skvl_pkg::S_APPLY: begin
				if (!out_valid_q || !out_stall) begin
					go        = 1'b1;
					state_nxt = skvl_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = skvl_pkg::S_IDLE;
			end
		endcase
	end

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= '{op: operation, key: item_key, value: item_value, pos: position};
		end
	end

	// cell row
	for (genvar i = 0; i < skvl_pkg::CAPACITY; i++) begin : g_cell
		logic [skvl_pkg::KEY_W-1:0]        lk, rk;
		logic signed [skvl_pkg::VAL_W-1:0] lv, rv;

		if (i == 0) begin : g_first
			assign lk = item_q.key;
			assign lv = item_q.value;
		end else begin : g_mid_l
			assign lk = key_a[i-1];
			assign lv = val_a[i-1];
		end
		if (i == skvl_pkg::CAPACITY - 1) begin : g_last
			assign rk = key_a[i];
			assign rv = val_a[i];
		end else begin : g_mid_r
			assign rk = key_a[i+1];
			assign rv = val_a[i+1];
		end

		skvl_cell u_cell (
			.clk         (clk),
			.idx         (skvl_pkg::POS_W'(i)),
			.item        (item_q),
			.cmp_en      (cmp_en),
			.cmd         (cell_cmd),
			.left_key    (lk),
			.left_value  (lv),
			.right_key   (rk),
			.right_value (rv),
			.key_q       (key_a[i]),
			.value_q     (val_a[i]),
			.gt_q        (gt_vec[i]),
			.match_q     (match_vec[i])
		);
	end

	// slot selection and result
	skvl_pick u_pick (
		.item      (item_q),
		.count     (count_q),
		.gt_vec    (gt_vec),
		.match_vec (match_vec),
		.keys      (key_a),
		.values    (val_a),
		.res       (res),
		.cmd       (cmd)
	);

	// shifts only land when the result is written
	always_comb begin
		cell_cmd     = cmd;
		cell_cmd.ins = cmd.ins && go;
		cell_cmd.del = cmd.del && go;
	end

	// entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				count_q     <= res.count;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (go) begin
			out_res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_res_q.status;
	assign found_key      = out_res_q.key;
	assign found_value    = out_res_q.value;
	assign found_position = out_res_q.pos;
	assign entry_count    = skvl_pkg::OCNT_W'(out_res_q.count);

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= skvl_pkg::CNT_W'(skvl_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	// count moves only when a result is written
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(count_q))
		else $error("entry count changed without a result");

	// every applied beat shows up at the output
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid)
		else $error("applied beat produced no result");

	// a refused insert only happens on a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == skvl_pkg::STAT_FULL)) |->
		(entry_count == skvl_pkg::OCNT_W'(skvl_pkg::CAPACITY)))
		else $error("full status with list not full");

endmodule
`default_nettype wire

@@ src/skvl_cell.sv @@
// one list slot: holds a key/value pair, compares it and shifts with its neighbors
`default_nettype none
module skvl_cell (
	input  wire logic                              clk,
	input  wire logic [skvl_pkg::POS_W-1:0]        idx,
	input  wire skvl_pkg::item_t                   item,
	input  wire logic                              cmp_en,
	input  wire skvl_pkg::cmd_t                    cmd,
	input  wire logic [skvl_pkg::KEY_W-1:0]        left_key,
	input  wire logic signed [skvl_pkg::VAL_W-1:0] left_value,
	input  wire logic [skvl_pkg::KEY_W-1:0]        right_key,
	input  wire logic signed [skvl_pkg::VAL_W-1:0] right_value,
	output logic [skvl_pkg::KEY_W-1:0]             key_q,
	output logic signed [skvl_pkg::VAL_W-1:0]      value_q,
	output logic                                   gt_q,
	output logic                                   match_q
);

	// compare flags against the pending beat
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			gt_q    <= (value_q > item.value);
			match_q <= (key_q == item.key);
		end
	end

	// slot contents: open a gap for insert, close one for delete
	always_ff @(posedge clk) begin
		if (cmd.ins && (idx > cmd.at)) begin
			key_q   <= left_key;
			value_q <= left_value;
		end else if (cmd.ins && (idx == cmd.at)) begin
			key_q   <= item.key;
			value_q <= item.value;
		end else if (cmd.del && (idx >= cmd.at)) begin
			key_q   <= right_key;
			value_q <= right_value;
		end
	end

endmodule
`default_nettype wire

@@ src/skvl_pick.sv @@
// locates the target slot from the cell flags, reads it and builds the result and shift command
`default_nettype none
module skvl_pick (
	input  wire skvl_pkg::item_t                   item,
	input  wire logic [skvl_pkg::CNT_W-1:0]        count,
	input  wire logic [skvl_pkg::CAPACITY-1:0]     gt_vec,
	input  wire logic [skvl_pkg::CAPACITY-1:0]     match_vec,
	input  wire logic [skvl_pkg::KEY_W-1:0]        keys   [skvl_pkg::CAPACITY],
	input  wire logic signed [skvl_pkg::VAL_W-1:0] values [skvl_pkg::CAPACITY],
	output skvl_pkg::res_t                         res,
	output skvl_pkg::cmd_t                         cmd
);

	logic [skvl_pkg::CAPACITY-1:0] live;
	logic [skvl_pkg::POS_W:0]      gt_hit;
	logic [skvl_pkg::POS_W:0]      key_hit;
	logic [skvl_pkg::POS_W-1:0]    sel;
	logic                          pos_ok;

	// only slots below the count take part
	always_comb begin
		for (int i = 0; i < skvl_pkg::CAPACITY; i++) begin
			live[i] = (skvl_pkg::CNT_W'(i) < count);
		end
	end

	assign gt_hit  = skvl_pkg::first_set(gt_vec & live);
	assign key_hit = skvl_pkg::first_set(match_vec & live);
	assign pos_ok  = (skvl_pkg::CNT_W'(item.pos) < count);

	// slot read for key and index operations
	always_comb begin
		if ((item.op == skvl_pkg::OP_REMOVE_KEY) || (item.op == skvl_pkg::OP_LOOKUP_KEY)) begin
			sel = key_hit[skvl_pkg::POS_W-1:0];
		end else begin
			sel = skvl_pkg::POS_W'(item.pos);
		end
	end

	// result and command per operation
	always_comb begin
		res        = '0;
		res.status = skvl_pkg::STAT_OK;
		res.count  = count;
		cmd        = '0;
		case (item.op)
			skvl_pkg::OP_INSERT: begin
				if (count == skvl_pkg::CNT_W'(skvl_pkg::CAPACITY)) begin
					res.status = skvl_pkg::STAT_FULL;
				end else begin
					cmd.ins = 1'b1;
					cmd.at  = gt_hit[skvl_pkg::POS_W] ? gt_hit[skvl_pkg::POS_W-1:0]
						: count[skvl_pkg::POS_W-1:0];
					res.key   = item.key;
					res.value = item.value;
					res.pos   = skvl_pkg::OPOS_W'(cmd.at);
					res.count = count + skvl_pkg::CNT_W'(1);
				end
			end
			skvl_pkg::OP_REMOVE_KEY, skvl_pkg::OP_LOOKUP_KEY: begin
				if (!key_hit[skvl_pkg::POS_W]) begin
					res.status = skvl_pkg::STAT_NOT_FOUND;
				end else begin
					res.key   = keys[sel];
					res.value = values[sel];
					res.pos   = skvl_pkg::OPOS_W'(sel);
					if (item.op == skvl_pkg::OP_REMOVE_KEY) begin
						cmd.del   = 1'b1;
						cmd.at    = sel;
						res.count = count - skvl_pkg::CNT_W'(1);
					end
				end
			end
			skvl_pkg::OP_REMOVE_INDEX, skvl_pkg::OP_LOOKUP_INDEX: begin
				if (!pos_ok) begin
					res.status = skvl_pkg::STAT_RANGE;
				end else begin
					res.key   = keys[sel];
					res.value = values[sel];
					res.pos   = skvl_pkg::OPOS_W'(sel);
					if (item.op == skvl_pkg::OP_REMOVE_INDEX) begin
						cmd.del   = 1'b1;
						cmd.at    = sel;
						res.count = count - skvl_pkg::CNT_W'(1);
					end
				end
			end
			default: begin
				res.status = skvl_pkg::STAT_OK;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// self-checking testbench of the sorted key/value list
`timescale 1ns / 100ps
module tb_top;
	import skvl_pkg::*;

	localparam int RANDOM_OPS  = 900;
	localparam int QUIET_TAIL  = 120;
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	// whole list contents as seen by the predictor
	typedef struct packed {
		logic [CNT_W-1:0]                 count;
		logic [CAPACITY-1:0][KEY_W-1:0]   keys;
		logic [CAPACITY-1:0][VAL_W-1:0]   vals;
	} list_t;

	// one pending beat and whether to wait for all results before sending it
	typedef struct packed {
		item_t beat;
		logic  drain;
	} pending_t;

	// traffic shape of the random part
	typedef enum logic [1:0] {
		M_FILL,
		M_MIX,
		M_DRAIN
	} mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [OP_W-1:0]          operation = '0;
	logic [KEY_W-1:0]         item_key = '0;
	logic signed [VAL_W-1:0]  item_value = '0;
	logic [IPOS_W-1:0]        position = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               status;
	logic [KEY_W-1:0]         found_key;
	logic signed [VAL_W-1:0]  found_value;
	logic [OPOS_W-1:0]        found_position;
	logic [OCNT_W-1:0]        entry_count;

	pending_t pending_ops[$];
	res_t     awaited_results[$];
	list_t    live_list;
	list_t    plan_list;
	item_t    cur_beat;
	pending_t next_op;
	res_t     want;
	logic     offer;
	logic     hold;
	logic     long_hold_done = 1'b0;
	int       gap_left = 0;
	int       hold_left = 0;
	int       sent_count = 0;
	int       recv_count = 0;
	int       quiet_from = 0;
	int       fail_count = 0;
	int       cycle_count = 0;

	sorted_key_value_list u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.item_key       (item_key),
		.item_value     (item_value),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_key      (found_key),
		.found_value    (found_value),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	// close the gap left by a removed entry
	function automatic void drop_entry(inout list_t s, input int at);
		for (int j = at; j + 1 < int'(s.count); j++) begin
			s.keys[j] = s.keys[j + 1];
			s.vals[j] = s.vals[j + 1];
		end
		s.count = s.count - 1'b1;
	endfunction

	// apply one operation to a list and return the result beat it produces
	function automatic res_t list_step(inout list_t s, input item_t it);
		res_t r;
		int   at;
		int   n;
		r = '0;
		r.status = STAT_OK;
		n = int'(s.count);
		case (it.op)
			OP_INSERT: begin
				if (n >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					// first strictly greater value, so ties land behind
					at = n;
					for (int j = n - 1; j >= 0; j--) begin
						if ($signed(it.value) < $signed(s.vals[j])) begin
							at = j;
						end
					end
					for (int j = n; j > at; j--) begin
						s.keys[j] = s.keys[j - 1];
						s.vals[j] = s.vals[j - 1];
					end
					s.keys[at] = it.key;
					s.vals[at] = it.value;
					s.count = s.count + 1'b1;
					r.key = it.key;
					r.value = it.value;
					r.pos = OPOS_W'(at);
				end
			end
			OP_REMOVE_KEY, OP_LOOKUP_KEY: begin
				at = n;
				for (int j = n - 1; j >= 0; j--) begin
					if (s.keys[j] == it.key) begin
						at = j;
					end
				end
				if (at >= n) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					r.key = s.keys[at];
					r.value = s.vals[at];
					r.pos = OPOS_W'(at);
					if (it.op == OP_REMOVE_KEY) begin
						drop_entry(s, at);
					end
				end
			end
			OP_REMOVE_INDEX, OP_LOOKUP_INDEX: begin
				at = int'(it.pos);
				if (at >= n) begin
					r.status = STAT_RANGE;
				end else begin
					r.key = s.keys[at];
					r.value = s.vals[at];
					r.pos = OPOS_W'(at);
					if (it.op == OP_REMOVE_INDEX) begin
						drop_entry(s, at);
					end
				end
			end
			default: begin
			end
		endcase
		r.count = s.count;
		return r;
	endfunction

	task automatic report_error(input string msg);
		fail_count++;
		$display("ERROR @%0t result %0d: %s", $time, recv_count, msg);
	endtask

	// queue one beat, tracking the list it will see
	task automatic queue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val, input logic [IPOS_W-1:0] pos, input logic drain);
		pending_t p;
		p.beat.op = op;
		p.beat.key = key;
		p.beat.value = val;
		p.beat.pos = pos;
		p.drain = drain;
		void'(list_step(plan_list, p.beat));
		pending_ops.insert(pending_ops.size(), p);
	endtask

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// stimulus plan, reset and end of run
	initial begin
		mode_t                   mode;
		logic                    filled_last;
		int                      mix_left;
		int                      edge_hits;
		int                      roll;
		int                      cnt;
		logic [OP_W-1:0]         op;
		logic [KEY_W-1:0]        key;
		logic [VAL_W-1:0]        val;
		logic [IPOS_W-1:0]       pos;
		live_list = '0;
		plan_list = '0;

		// empty list corners
		queue_op(OP_LOOKUP_KEY, 16'd0, 32'd0, 5'd0, 1'b0);
		queue_op(OP_REMOVE_INDEX, 16'd0, 32'd0, 5'd0, 1'b0);
		queue_op(OP_REMOVE_KEY, 16'hFFFF, 32'd0, 5'd0, 1'b0);
		queue_op(OP_LOOKUP_INDEX, 16'd0, 32'd0, 5'd31, 1'b0);
		// value extremes and ties
		queue_op(OP_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 5'd0, 1'b0);
		queue_op(OP_INSERT, 16'd0, 32'h8000_0000, 5'd31, 1'b0);
		queue_op(OP_INSERT, 16'd5, 32'd0, 5'd0, 1'b0);
		queue_op(OP_INSERT, 16'd6, 32'd0, 5'd0, 1'b0);
		queue_op(OP_INSERT, 16'd5, 32'd0, 5'd0, 1'b0);
		queue_op(OP_INSERT, 16'h8000, 32'hFFFF_FFFF, 5'd0, 1'b0);
		// lookups: first match, both ends, one past the end
		queue_op(OP_LOOKUP_KEY, 16'd5, 32'd0, 5'd0, 1'b0);
		queue_op(OP_LOOKUP_INDEX, 16'd0, 32'd0, 5'd0, 1'b0);
		queue_op(OP_LOOKUP_INDEX, 16'd0, 32'd0, 5'd5, 1'b0);
		queue_op(OP_LOOKUP_INDEX, 16'd0, 32'd0, 5'd6, 1'b0);
		// unused opcodes leave the list alone
		queue_op(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b0);
		queue_op(3'd6, 16'd5, 32'd0, 5'd0, 1'b0);
		queue_op(3'd7, 16'hA5A5, 32'h5A5A_5A5A, 5'd21, 1'b0);
		// removes
		queue_op(OP_REMOVE_KEY, 16'd5, 32'd0, 5'd0, 1'b0);
		queue_op(OP_REMOVE_INDEX, 16'd0, 32'd0, 5'd0, 1'b0);
		queue_op(OP_REMOVE_INDEX, 16'd0, 32'd0, 5'd3, 1'b0);
		queue_op(OP_REMOVE_INDEX, 16'd0, 32'd0, 5'd31, 1'b0);
		queue_op(OP_LOOKUP_KEY, 16'd1, 32'd0, 5'd0, 1'b0);
		queue_op(OP_REMOVE_KEY, 16'h8000, 32'd0, 5'd0, 1'b0);

		// random part cycles fill, mix, drain, mix
		mode = M_FILL;
		filled_last = 1'b0;
		mix_left = 0;
		edge_hits = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			cnt = int'(plan_list.count);
			roll = $urandom_range(0, 99);
			case (mode)
				M_FILL: begin
					op = (roll < 75) ? OP_INSERT : OP_W'($urandom_range(1, 4));
				end
				M_DRAIN: begin
					if (roll < 40) begin
						op = OP_REMOVE_KEY;
					end else if (roll < 75) begin
						op = OP_REMOVE_INDEX;
					end else if (roll < 85) begin
						op = OP_INSERT;
					end else begin
						op = (roll < 92) ? OP_LOOKUP_KEY : OP_LOOKUP_INDEX;
					end
				end
				default: begin
					op = (roll < 3) ? OP_W'($urandom_range(5, 7)) : OP_W'($urandom_range(0, 4));
				end
			endcase

			// keys mostly from a small pool or the list itself so searches hit
			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				key = KEY_W'($urandom_range(0, 15));
			end else if (roll < 7 && cnt > 0) begin
				key = plan_list.keys[$urandom_range(0, cnt - 1)];
			end else begin
				key = KEY_W'($urandom_range(0, 65535));
			end

			// values: anything, a few whole numbers, extremes, or copies for ties
			roll = $urandom_range(0, 9);
			if (roll < 4) begin
				val = $urandom();
			end else if (roll < 6) begin
				val = VAL_W'((int'($urandom_range(0, 4)) - 2) * 65536);
			end else if (roll < 7) begin
				val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			end else if (cnt > 0) begin
				val = plan_list.vals[$urandom_range(0, cnt - 1)];
			end else begin
				val = $urandom();
			end

			if ($urandom_range(0, 9) < 7 && cnt > 0) begin
				pos = IPOS_W'($urandom_range(0, cnt - 1));
			end else begin
				pos = IPOS_W'($urandom_range(0, 31));
			end

			queue_op(op, key, val, pos, (n == 250 || n == 620));

			// mode changes
			cnt = int'(plan_list.count);
			case (mode)
				M_FILL: begin
					if (cnt == CAPACITY && op == OP_INSERT) begin
						edge_hits++;
					end
					if (edge_hits >= 4) begin
						mode = M_MIX;
						mix_left = 60;
						filled_last = 1'b1;
						edge_hits = 0;
					end
				end
				M_DRAIN: begin
					if (cnt == 0) begin
						edge_hits++;
					end
					if (edge_hits >= 3) begin
						mode = M_MIX;
						mix_left = 60;
						filled_last = 1'b0;
						edge_hits = 0;
					end
				end
				default: begin
					mix_left--;
					if (mix_left <= 0) begin
						mode = filled_last ? M_DRAIN : M_FILL;
					end
				end
			endcase
		end
		quiet_from = pending_ops.size() - QUIET_TAIL;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for everything sent and answered, then a short tail
		while (pending_ops.size() != 0 || in_valid || awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (30) @(posedge clk);
		if (awaited_results.size() != 0) begin
			report_error($sformatf("%0d results never arrived", awaited_results.size()));
		end
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			item_key <= '0;
			item_value <= '0;
			position <= '0;
		end else begin
			// accepted beat: predict its result
			if (in_valid && !in_stall) begin
				awaited_results.insert(awaited_results.size(), list_step(live_list, cur_beat));
				sent_count++;
			end
			// payload holds while stalled
			if (!(in_valid && in_stall)) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() > 0) begin
					if (pending_ops[0].drain && awaited_results.size() > 0) begin
						offer = 1'b0;
					end else if (sent_count < quiet_from && $urandom_range(0, 9) == 0) begin
						gap_left = $urandom_range(1, 18) - 1;
					end else begin
						next_op = pending_ops.pop_front();
						cur_beat = next_op.beat;
						offer = 1'b1;
					end
				end
				in_valid <= offer;
				if (offer) begin
					operation <= cur_beat.op;
					item_key <= cur_beat.key;
					item_value <= cur_beat.value;
					position <= cur_beat.pos;
				end
			end
		end
	end

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report_error("result beat with no operation outstanding");
				end else begin
					want = awaited_results.pop_front();
					if (status !== want.status) begin
						report_error($sformatf("status got %0d want %0d", status, want.status));
					end
					if (found_key !== want.key) begin
						report_error($sformatf("found_key got %h want %h", found_key, want.key));
					end
					if (found_value !== want.value) begin
						report_error($sformatf("found_value got %h want %h",
							found_value, want.value));
					end
					if (found_position !== want.pos) begin
						report_error($sformatf("found_position got %0d want %0d",
							found_position, want.pos));
					end
					if (entry_count !== OCNT_W'(want.count)) begin
						report_error($sformatf("entry_count got %0d want %0d",
							entry_count, want.count));
					end
				end
				recv_count++;
			end
			// one long hold-off to back the list up, otherwise short bursts
			if (hold_left > 0) begin
				hold_left--;
				hold = 1'b1;
			end else if (!long_hold_done && recv_count >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES - 1;
				long_hold_done = 1'b1;
				hold = 1'b1;
			end else if (recv_count < quiet_from && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(1, 18) - 1;
				hold = 1'b1;
			end else begin
				hold = 1'b0;
			end
			out_stall <= hold;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
